/* hdl/rsk_pkg.sv */
// ----------------------------------------------------------------------------
// rsk_pkg
// Shared types and constants for the record sort unit.
// ----------------------------------------------------------------------------
package rsk_pkg;

    localparam int unsigned KEY_W           = 12;
    localparam int unsigned TAG_W           = 16;
    localparam int unsigned MAX_RECORDS_DEF = 64;

    typedef struct packed {
        logic [KEY_W-1:0] grade_key;
        logic [TAG_W-1:0] record_tag;
        logic             last_record;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic [TAG_W-1:0] sorted_tag;
        logic             run_end;
        logic             overflowed;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;   // insert the input item into the cell chain
        logic shift;  // move the chain one place toward the head
        logic clear;  // empty the chain and the drop flag
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;  // no record held
        logic one;    // exactly one record held
    } t_dp_sts;

endpackage

/* hdl/rsk_datapath.sv */
// ----------------------------------------------------------------------------
// rsk_datapath
// Insertion cell chain: each cell holds one record; an arriving record is
// placed after every held record with a key less than or equal to its own.
// ----------------------------------------------------------------------------
module rsk_datapath
    import rsk_pkg::*;
#(
    parameter int unsigned MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  t_in_item             i_item,
    output t_dp_sts              o_sts,
    output logic [KEY_W-1:0]     o_head_key,
    output logic [TAG_W-1:0]     o_head_tag,
    output logic                 o_dropped
);

    logic [KEY_W-1:0]       r_key [MAX_RECORDS];
    logic [TAG_W-1:0]       r_tag [MAX_RECORDS];
    logic [MAX_RECORDS-1:0] r_vld;
    logic                   r_drop;
    logic [MAX_RECORDS-1:0] w_gt;
    logic                   w_full;

    // per-cell compare: held record moves down if its key is greater
    always_comb begin
        for (int i = 0; i < MAX_RECORDS; i++) begin
            w_gt[i] = r_vld[i] && (r_key[i] > i_item.grade_key);
        end
    end

    assign w_full = r_vld[MAX_RECORDS-1];

    // cell payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RECORDS; i++) begin
            if (i_cmd.shift) begin
                if (i < MAX_RECORDS - 1) begin
                    r_key[i] <= r_key[(i + 1) % MAX_RECORDS];
                    r_tag[i] <= r_tag[(i + 1) % MAX_RECORDS];
                end
            end else if (i_cmd.load && !w_full) begin
                if (w_gt[i]) begin
                    if (i > 0) begin
                        if (!w_gt[(i + MAX_RECORDS - 1) % MAX_RECORDS]) begin
                            r_key[i] <= i_item.grade_key;
                            r_tag[i] <= i_item.record_tag;
                        end else begin
                            r_key[i] <= r_key[(i + MAX_RECORDS - 1) % MAX_RECORDS];
                            r_tag[i] <= r_tag[(i + MAX_RECORDS - 1) % MAX_RECORDS];
                        end
                    end else begin
                        r_key[i] <= i_item.grade_key;
                        r_tag[i] <= i_item.record_tag;
                    end
                end else if (!r_vld[i] && (i == 0 || r_vld[(i + MAX_RECORDS - 1) % MAX_RECORDS]))
                begin
                    // first free cell takes the displaced tail or the new record
                    if (i > 0 && w_gt[(i + MAX_RECORDS - 1) % MAX_RECORDS]) begin
                        r_key[i] <= r_key[(i + MAX_RECORDS - 1) % MAX_RECORDS];
                        r_tag[i] <= r_tag[(i + MAX_RECORDS - 1) % MAX_RECORDS];
                    end else begin
                        r_key[i] <= i_item.grade_key;
                        r_tag[i] <= i_item.record_tag;
                    end
                end
            end
        end
    end

    // occupancy and drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_vld  <= '0;
            r_drop <= 1'b0;
        end else if (i_cmd.shift) begin
            r_vld <= r_vld >> 1;
        end else if (i_cmd.load) begin
            if (w_full) begin
                r_drop <= 1'b1;
            end else begin
                r_vld <= {r_vld[MAX_RECORDS-2:0], 1'b1};
            end
        end
    end

    assign o_head_key = r_key[0];
    assign o_head_tag = r_tag[0];
    assign o_dropped  = r_drop;
    assign o_sts.empty = !r_vld[0];
    assign o_sts.one   = r_vld[0] && !r_vld[1];

endmodule

/* hdl/rsk_ctrl.sv */
// ----------------------------------------------------------------------------
// rsk_ctrl
// Controller: loads items until the last one, then drains the chain through
// the output register one record per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module rsk_ctrl
    import rsk_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_last,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    output logic     o_out_load,
    output logic     o_out_end,
    input  t_dp_sts  i_sts,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_ovld;
    logic   w_take;

    // output register may be refilled when empty or being taken
    assign w_take = (r_state == ST_DRAIN) && !i_sts.empty && (!r_ovld || i_out_ready);

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = r_ovld;
    assign o_out_load  = w_take;
    assign o_out_end   = i_sts.one;

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = o_in_ready && i_in_valid;
        o_cmd.shift = w_take;
        o_cmd.clear = w_take && i_sts.one;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (i_in_valid && i_in_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (w_take && i_sts.one) n_state = ST_LOAD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_take) r_ovld <= 1'b1;
            else if (i_out_ready) r_ovld <= 1'b0;
        end
    end

    // drain only starts with something held
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD && n_state == ST_DRAIN) |=> !i_sts.empty)
        else $error("drain started on empty chain");
    // no input accepted while draining
    a_no_load_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> !o_cmd.load)
        else $error("load during drain");
    // a stalled result is not overwritten
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !i_out_ready) |-> !w_take)
        else $error("output overwritten");

endmodule

/* hdl/record_sort_by_key_unit.sv */
// ----------------------------------------------------------------------------
// record_sort_by_key_unit
// Stable ascending sort of a run of records by grade key.
// ----------------------------------------------------------------------------
// Usage: records enter on the i_in channel (valid/ready), one per cycle,
// each with a 12-bit key and a 16-bit tag; last_record closes the run.
// An insertion cell chain places every record as it arrives, after held
// records of equal key, so equal keys leave in load order. Records beyond
// MAX_RECORDS are dropped and every result of that run has overflowed set.
// After the last record the chain drains to the o_out channel one record
// per cycle through an output register; run_end marks the final result.
// Input is not accepted while a run drains. Each result passes through
// the output register before it appears on o_out. A receiver stall
// holds the output register and pauses the drain. Reset empties the
// chain and clears the drop flag.
// ----------------------------------------------------------------------------
module record_sort_by_key_unit
    import rsk_pkg::*;
#(
    parameter int unsigned MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic [KEY_W-1:0] w_hkey;
    logic [TAG_W-1:0] w_htag;
    logic             w_drop, w_oload, w_oend;
    t_out_item        r_out;

    rsk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.last_record),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_load  (w_oload),
        .o_out_end   (w_oend),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rsk_datapath #(.MAX_RECORDS(MAX_RECORDS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_item     (i_in_data),
        .o_sts      (w_sts),
        .o_head_key (w_hkey),
        .o_head_tag (w_htag),
        .o_dropped  (w_drop)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (w_oload) begin
            r_out.sorted_key <= w_hkey;
            r_out.sorted_tag <= w_htag;
            r_out.run_end    <= w_oend;
            r_out.overflowed <= w_drop;
        end
    end

    assign o_out_data = r_out;

endmodule
